// File: src/ugtb_pkg.sv
// Shared types and constants for the grouped-undo text buffer.
package ugtb_pkg;

  localparam int OP_W       = 3;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int CFG_W      = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [0:0]       REG_GROUP_LIMIT   = 1'b0;
  localparam logic [CFG_W-1:0] GROUP_LIMIT_RESET = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_TYPE   = 3'd0,
    OP_DELETE = 3'd1,
    OP_UNDO   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_UNDO    = 3'd1,
    ST_NO_DELETE  = 3'd2,
    ST_TEXT_FULL  = 3'd3,
    ST_STACK_FULL = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DEL,
    S_RESTORE,
    S_POP,
    S_REFILL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    load_in;
    logic    set_status;
    status_e status;
    logic    type_wr;
    logic    del_rd;
    logic    del_apply;
    logic    undo_trunc;
    logic    undo_start;
    logic    restore;
    logic    pop;
    logic    refill;
    logic    clear;
    logic    idx_rd;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            text_empty;
    logic            text_full;
    logic            stack_empty;
    logic            stack_full;
    logic            join_type;
    logic            join_del;
    logic            top_is_del;
    logic            k_zero;
    logic            pend;
  } stat_t;

endpackage

// File: src/undo_grouped_text_buffer.sv
// Top level: grouped-undo text buffer with APB group-limit register.
//
// Input channel (in_valid_i / in_stall_o) takes one operation word: opcode_i,
// char_in_i, read_index_i. Output channel (out_valid_o / out_stall_i) returns
// exactly one result word per operation: status, text length, read char,
// stack depth and top undo entry.
// One operation is in flight at a time; in_stall_o is low only in idle.
// States from accept to output word valid (every path ends in S_DONE): type,
// clear, read, unused opcodes, rejected edits: S_DECODE; delete: S_DECODE,
// S_DEL; undo of a typing run: S_DECODE, S_POP, S_REFILL; undo of a deletion
// run: S_DECODE, S_RESTORE (one text-store write per cycle, fed by the
// registered read of the deleted-character memory), S_POP, S_REFILL.
// The next word can be taken in the cycle after the result is loaded.
// If the receiver stalls, the result waits in the output register and the
// block holds its finished operation until that register frees up.
// Reset clears text length, stack depth and handshake state and sets the
// group limit to 4; memories are not cleared and need no clearing pass.
// The group limit register sits at APB byte address 0.
module undo_grouped_text_buffer #(
  parameter int TEXT_DEPTH = 256,
  parameter int UNDO_DEPTH = 64,
  parameter int GROUP_MAX  = 4,
  localparam int LW   = $clog2(TEXT_DEPTH + 1),
  localparam int SW   = $clog2(UNDO_DEPTH + 1),
  localparam int CNTW = $clog2(GROUP_MAX + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ugtb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ugtb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ugtb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ugtb_pkg::OP_W-1:0]       opcode_i,
  input  logic [ugtb_pkg::CHAR_W-1:0]     char_in_i,
  input  logic [ugtb_pkg::IDX_W-1:0]      read_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ugtb_pkg::STATUS_W-1:0]   status_o,
  output logic [LW-1:0]                   text_length_o,
  output logic [ugtb_pkg::CHAR_W-1:0]     read_char_o,
  output logic [SW-1:0]                   stack_depth_o,
  output logic                            top_kind_o,
  output logic [CNTW-1:0]                 top_count_o
);
  import ugtb_pkg::*;

  logic [CFG_W-1:0] group_limit_q;
  logic             reg_hit;
  cmd_t             cmd;
  stat_t            stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_GROUP_LIMIT);
  assign prdata  = reg_hit ? APB_DATA_W'(group_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_limit_q <= GROUP_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      group_limit_q <= pwdata[CFG_W-1:0];
    end
  end

  ugtb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ugtb_datapath #(
    .TEXT_DEPTH (TEXT_DEPTH),
    .UNDO_DEPTH (UNDO_DEPTH),
    .GROUP_MAX  (GROUP_MAX)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .group_limit_i (group_limit_q),
    .opcode_i      (opcode_i),
    .char_in_i     (char_in_i),
    .read_index_i  (read_index_i),
    .status_o      (status_o),
    .text_length_o (text_length_o),
    .read_char_o   (read_char_o),
    .stack_depth_o (stack_depth_o),
    .top_kind_o    (top_kind_o),
    .top_count_o   (top_count_o)
  );

endmodule

// File: src/ugtb_datapath.sv
// Datapath: text, undo-entry and deleted-character memories, counters and result word.
module ugtb_datapath #(
  parameter int TEXT_DEPTH = 256,
  parameter int UNDO_DEPTH = 64,
  parameter int GROUP_MAX  = 4,
  localparam int LW   = $clog2(TEXT_DEPTH + 1),
  localparam int SW   = $clog2(UNDO_DEPTH + 1),
  localparam int CNTW = $clog2(GROUP_MAX + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ugtb_pkg::cmd_t                cmd_i,
  output ugtb_pkg::stat_t               stat_o,
  input  logic [ugtb_pkg::CFG_W-1:0]    group_limit_i,
  input  logic [ugtb_pkg::OP_W-1:0]     opcode_i,
  input  logic [ugtb_pkg::CHAR_W-1:0]   char_in_i,
  input  logic [ugtb_pkg::IDX_W-1:0]    read_index_i,
  output logic [ugtb_pkg::STATUS_W-1:0] status_o,
  output logic [LW-1:0]                 text_length_o,
  output logic [ugtb_pkg::CHAR_W-1:0]   read_char_o,
  output logic [SW-1:0]                 stack_depth_o,
  output logic                          top_kind_o,
  output logic [CNTW-1:0]               top_count_o
);
  import ugtb_pkg::*;

  localparam int AW  = $clog2(TEXT_DEPTH);
  localparam int EW  = $clog2(UNDO_DEPTH);
  localparam int CD  = UNDO_DEPTH * GROUP_MAX;
  localparam int CAW = $clog2(CD);
  localparam int CW  = (LW > IDX_W) ? LW : IDX_W;

  logic [OP_W-1:0]   op_q;
  logic [CHAR_W-1:0] char_q;
  logic [IDX_W-1:0]  idx_q;
  logic [LW-1:0]     len_q, len_d;
  logic [SW-1:0]     sp_q, sp_d;
  logic              top_kind_q, top_kind_d;
  logic [CNTW-1:0]   top_cnt_q, top_cnt_d;
  logic [CNTW-1:0]   k_q, k_d;
  logic              pend_q, pend_d;
  logic              rd_ok_q;
  status_e           status_q;

  logic [CHAR_W-1:0] text_mem [TEXT_DEPTH];
  logic [CHAR_W-1:0] text_rdata_q;
  logic [CNTW:0]     ent_mem [UNDO_DEPTH];
  logic [CNTW:0]     ent_rdata_q;
  logic [CHAR_W-1:0] chr_mem [CD];
  logic [CHAR_W-1:0] chr_rdata_q;

  status_e           status_out_q;
  logic [LW-1:0]     len_out_q;
  logic [CHAR_W-1:0] rchar_out_q;
  logic [SW-1:0]     sp_out_q;
  logic              kind_out_q;
  logic [CNTW-1:0]   cnt_out_q;

  logic [CNTW-1:0]   lim;
  logic              text_full, text_empty, stack_full, stack_empty;
  logic              join_type, join_del, join_cur;
  logic [SW-1:0]     sp_m1, sp_m2;
  logic [LW-1:0]     len_m1;
  logic [EW-1:0]     top_idx, push_idx, ent_widx;
  logic [CNTW-1:0]   new_cnt;
  logic [CAW-1:0]    chr_waddr, chr_raddr;
  logic [CNTW-1:0]   k_m1;

  logic              text_we;
  logic [AW-1:0]     text_waddr, text_raddr;
  logic [CHAR_W-1:0] text_wdata;
  logic              text_re;

  always_comb begin
    if (group_limit_i == '0) begin
      lim = CNTW'(1);
    end else if (32'(group_limit_i) > GROUP_MAX) begin
      lim = CNTW'(GROUP_MAX);
    end else begin
      lim = CNTW'(group_limit_i);
    end
  end

  assign text_full   = (len_q == LW'(TEXT_DEPTH));
  assign text_empty  = (len_q == '0);
  assign stack_full  = (sp_q == SW'(UNDO_DEPTH));
  assign stack_empty = (sp_q == '0);
  assign join_type   = !stack_empty && !top_kind_q && (top_cnt_q < lim);
  assign join_del    = !stack_empty && top_kind_q && (top_cnt_q < lim);
  assign join_cur    = cmd_i.del_apply ? join_del : join_type;

  assign sp_m1    = sp_q - SW'(1);
  assign sp_m2    = sp_q - SW'(2);
  assign len_m1   = len_q - LW'(1);
  assign top_idx  = sp_m1[EW-1:0];
  assign push_idx = sp_q[EW-1:0];
  assign ent_widx = join_cur ? top_idx : push_idx;
  assign new_cnt  = join_cur ? top_cnt_q + CNTW'(1) : CNTW'(1);
  assign k_m1     = k_q - CNTW'(1);

  assign chr_waddr = join_del
      ? CAW'(CAW'(top_idx) * CAW'(GROUP_MAX) + CAW'(top_cnt_q))
      : CAW'(CAW'(push_idx) * CAW'(GROUP_MAX));
  assign chr_raddr = CAW'(CAW'(top_idx) * CAW'(GROUP_MAX) + CAW'(k_m1));

  always_comb begin
    text_we    = 1'b0;
    text_waddr = len_q[AW-1:0];
    text_wdata = char_q;
    if (cmd_i.type_wr) begin
      text_we = 1'b1;
    end else if (cmd_i.restore && pend_q && !text_full) begin
      text_we    = 1'b1;
      text_wdata = chr_rdata_q;
    end
    text_re    = cmd_i.del_rd || cmd_i.idx_rd;
    text_raddr = cmd_i.del_rd ? len_m1[AW-1:0] : AW'(idx_q);
  end

  always_comb begin
    len_d      = len_q;
    sp_d       = sp_q;
    top_kind_d = top_kind_q;
    top_cnt_d  = top_cnt_q;
    k_d        = k_q;
    pend_d     = pend_q;
    if (cmd_i.type_wr || cmd_i.del_apply) begin
      len_d      = cmd_i.type_wr ? len_q + LW'(1) : len_m1;
      sp_d       = join_cur ? sp_q : sp_q + SW'(1);
      top_kind_d = cmd_i.del_apply;
      top_cnt_d  = new_cnt;
    end
    if (cmd_i.undo_trunc) begin
      len_d = (LW'(top_cnt_q) > len_q) ? '0 : len_q - LW'(top_cnt_q);
    end
    if (cmd_i.undo_start) begin
      k_d = top_cnt_q;
    end
    if (cmd_i.restore) begin
      if (k_q != '0) begin
        k_d    = k_m1;
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
      if (pend_q && !text_full) begin
        len_d = len_q + LW'(1);
      end
    end
    if (cmd_i.pop) begin
      sp_d = sp_m1;
    end
    if (cmd_i.refill && !stack_empty) begin
      top_kind_d = ent_rdata_q[CNTW];
      top_cnt_d  = ent_rdata_q[CNTW-1:0];
    end
    if (cmd_i.clear) begin
      len_d = '0;
      sp_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      sp_q   <= '0;
      k_q    <= '0;
      pend_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      sp_q   <= sp_d;
      k_q    <= k_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_kind_q <= top_kind_d;
    top_cnt_q  <= top_cnt_d;
    if (cmd_i.load_in) begin
      op_q   <= opcode_i;
      char_q <= char_in_i;
      idx_q  <= read_index_i;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.idx_rd) begin
      rd_ok_q <= (CW'(idx_q) < CW'(len_q));
    end
    if (cmd_i.load_out) begin
      status_out_q <= status_q;
      len_out_q    <= len_q;
      rchar_out_q  <= (op_q == OP_READ && rd_ok_q) ? text_rdata_q : '0;
      sp_out_q     <= sp_q;
      kind_out_q   <= stack_empty ? 1'b0 : top_kind_q;
      cnt_out_q    <= stack_empty ? '0 : top_cnt_q;
    end
  end

  // text store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[text_waddr] <= text_wdata;
    end
    if (text_re) begin
      text_rdata_q <= text_mem[text_raddr];
    end
  end

  // undo entry kind and count
  always_ff @(posedge clk_i) begin
    if (cmd_i.type_wr || cmd_i.del_apply) begin
      ent_mem[ent_widx] <= {cmd_i.del_apply, new_cnt};
    end
    if (cmd_i.pop) begin
      ent_rdata_q <= ent_mem[sp_m2[EW-1:0]];
    end
  end

  // deleted characters, GROUP_MAX slots per entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.del_apply) begin
      chr_mem[chr_waddr] <= text_rdata_q;
    end
    if (cmd_i.restore && k_q != '0) begin
      chr_rdata_q <= chr_mem[chr_raddr];
    end
  end

  always_comb begin
    stat_o.opcode      = op_q;
    stat_o.text_empty  = text_empty;
    stat_o.text_full   = text_full;
    stat_o.stack_empty = stack_empty;
    stat_o.stack_full  = stack_full;
    stat_o.join_type   = join_type;
    stat_o.join_del    = join_del;
    stat_o.top_is_del  = top_kind_q;
    stat_o.k_zero      = (k_q == '0);
    stat_o.pend        = pend_q;
  end

  assign status_o      = status_out_q;
  assign text_length_o = len_out_q;
  assign read_char_o   = rchar_out_q;
  assign stack_depth_o = sp_out_q;
  assign top_kind_o    = kind_out_q;
  assign top_count_o   = cnt_out_q;

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q <= LW'(TEXT_DEPTH)) && (sp_q <= SW'(UNDO_DEPTH)))
    else $error("text length or stack depth out of range");

  a_top_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q != '0) |-> (top_cnt_q != '0))
    else $error("top entry cached with zero count");

  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> $past(cmd_i.restore))
    else $error("restore read pending without restore command");

endmodule

// File: src/ugtb_ctrl.sv
// Controller: sequences one operation at a time and owns both handshakes.
module ugtb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  ugtb_pkg::stat_t stat_i,
  output ugtb_pkg::cmd_t  cmd_o
);
  import ugtb_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.set_status = 1'b1;
        cmd_o.status     = ST_OK;
        state_d          = S_DONE;
        case (op_e'(stat_i.opcode))
          OP_TYPE: begin
            if (stat_i.text_full) begin
              cmd_o.status = ST_TEXT_FULL;
            end else if (!stat_i.join_type && stat_i.stack_full) begin
              cmd_o.status = ST_STACK_FULL;
            end else begin
              cmd_o.type_wr = 1'b1;
            end
          end
          OP_DELETE: begin
            if (stat_i.text_empty) begin
              cmd_o.status = ST_NO_DELETE;
            end else if (!stat_i.join_del && stat_i.stack_full) begin
              cmd_o.status = ST_STACK_FULL;
            end else begin
              cmd_o.del_rd = 1'b1;
              state_d      = S_DEL;
            end
          end
          OP_UNDO: begin
            if (stat_i.stack_empty) begin
              cmd_o.status = ST_NO_UNDO;
            end else if (stat_i.top_is_del) begin
              cmd_o.undo_start = 1'b1;
              state_d          = S_RESTORE;
            end else begin
              cmd_o.undo_trunc = 1'b1;
              state_d          = S_POP;
            end
          end
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
          end
          OP_READ: begin
            cmd_o.idx_rd = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_DEL: begin
        cmd_o.del_apply = 1'b1;
        state_d         = S_DONE;
      end
      S_RESTORE: begin
        cmd_o.restore = 1'b1;
        if (stat_i.k_zero && !stat_i.pend) begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_REFILL;
      end
      S_REFILL: begin
        cmd_o.refill = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECODE))
    else $error("accepted word did not start decode");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=>
      (state_q == S_DONE && out_valid_q))
    else $error("result overwrote a stalled output word");

  a_restore_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESTORE && state_d == S_POP) |-> (stat_i.k_zero && !stat_i.pend))
    else $error("restore left with characters outstanding");

endmodule
